### rtl/core/htm_pkg.sv
// shared types, constants and constant tables for the hdr tone mapper
// no dependencies
package htm_pkg;

    localparam int LANES     = 4;
    localparam int SAMPLE_W  = 32;
    localparam int RATIO_W   = 16;
    localparam int FRAC_W    = 20;
    localparam int EXPX_W    = 30;
    localparam int VAL_W     = 31;
    localparam int STEP_W    = 5;

    localparam logic [SAMPLE_W-1:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [VAL_W-1:0]    ONE_Q30   = 31'h4000_0000;
    localparam logic [30:0]         LOG2E_Q30 = 31'd1549082005;
    localparam logic [7:0]          BYTE_FULL = 8'd255;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_SCAN    = 2'd1;
    localparam logic [1:0] CMD_CONVERT = 2'd2;

    localparam logic [1:0] REG_EXPOSURE  = 2'd0;
    localparam logic [1:0] REG_INV_GAMMA = 2'd1;
    localparam logic [1:0] REG_CHANNELS  = 2'd2;

    typedef enum logic [3:0] {
        LN_IDLE,
        LN_DIV,
        LN_NORM,
        LN_LOG,
        LN_GAMMA,
        LN_EXP,
        LN_SHIFT,
        LN_EXPO,
        LN_LOG2E,
        LN_FINAL
    } lane_phase_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_BUSY,
        TOP_HOLD
    } top_state_t;

    typedef struct packed {
        logic [15:0]         exposure;
        logic [15:0]         inv_gamma;
        logic [SAMPLE_W-1:0] max;
    } lane_cfg_t;

    typedef struct packed {
        logic       load;
        logic [2:0] count;
        logic       last;
    } merge_ctl_t;

    typedef logic [FRAC_W-1:0][VAL_W-1:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = n;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(-2^-(k+1)) in q.30 for entry k, each a square root of the one before
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] r;
        r      = isqrt64(64'd1 << 59);
        tab[0] = r[VAL_W-1:0];
        for (int i = 1; i < FRAC_W; i++)
        begin
            r      = isqrt64(r << 30);
            tab[i] = r[VAL_W-1:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

### rtl/core/hdr_exponential_tone_mapper_unit.sv
// top level of the hdr exponential tone mapper: config, running maximum, control
// depends on htm_pkg, htm_lane, htm_merge
// Clear and scan items are taken while idle and give no result. A convert
// item is worked by each of the four channel lanes, which steps its own
// datapath through 16 division steps, 20 logarithm squarings, a gamma
// product, two exp2 passes of 20 root products each and the byte scaling.
// The next item is accepted once the result sits in the output register,
// even while it still waits to be taken.
module hdr_exponential_tone_mapper_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] sample_red,
    input  logic [31:0] sample_green,
    input  logic [31:0] sample_blue,
    input  logic [31:0] sample_alpha,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        last_pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import htm_pkg::*;

    top_state_t state_reg, state_next;
    logic [15:0]         exposure_reg;
    logic [15:0]         inv_gamma_reg;
    logic [2:0]          channels_reg;
    logic [SAMPLE_W-1:0] running_max_reg, running_max_next;
    logic                last_reg;

    logic                          accept;
    logic                          start;
    logic [2:0]                    eff_count;
    logic [LANES-1:0][SAMPLE_W-1:0] samples;
    logic [LANES-1:0][SAMPLE_W-1:0] cand;
    logic [SAMPLE_W-1:0]           max_lo;
    logic [SAMPLE_W-1:0]           max_hi;
    logic [SAMPLE_W-1:0]           max_all;
    logic [LANES-1:0]              lane_done;
    logic [LANES-1:0][7:0]         lane_bytes;
    logic                          lanes_done;
    logic                          merge_free;
    lane_cfg_t                     lane_cfg;
    merge_ctl_t                    merge_ctl;

    assign samples   = {sample_alpha, sample_blue, sample_green, sample_red};
    assign in_ready  = state_reg == TOP_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign start     = accept && command == CMD_CONVERT;
    assign lanes_done = &lane_done;

    always_comb
    begin
        if (channels_reg == 3'd0)
        begin
            eff_count = 3'd1;
        end
        else if (channels_reg > 3'(LANES))
        begin
            eff_count = 3'(LANES);
        end
        else
        begin
            eff_count = channels_reg;
        end
        for (int k = 0; k < LANES; k++)
        begin
            cand[k] = (3'(k) < eff_count) ? samples[k] : '0;
        end
        max_lo  = (cand[0] > cand[1]) ? cand[0] : cand[1];
        max_hi  = (cand[2] > cand[3]) ? cand[2] : cand[3];
        max_all = (max_lo > max_hi) ? max_lo : max_hi;
        running_max_next = running_max_reg;
        if (accept && command == CMD_CLEAR)
        begin
            running_max_next = ONE_Q16;
        end
        else if (accept && command == CMD_SCAN && max_all > running_max_reg)
        begin
            running_max_next = max_all;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        merge_ctl  = '{load: 1'b0, count: eff_count, last: last_reg};
        unique case (state_reg)
            TOP_IDLE:
            begin
                if (start)
                begin
                    state_next = TOP_BUSY;
                end
            end
            TOP_BUSY:
            begin
                if (lanes_done)
                begin
                    if (merge_free)
                    begin
                        merge_ctl.load = 1'b1;
                        state_next     = TOP_IDLE;
                    end
                    else
                    begin
                        state_next = TOP_HOLD;
                    end
                end
            end
            TOP_HOLD:
            begin
                if (merge_free)
                begin
                    merge_ctl.load = 1'b1;
                    state_next     = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= TOP_IDLE;
            exposure_reg    <= 16'd256;
            inv_gamma_reg   <= 16'd1862;
            channels_reg    <= 3'd4;
            running_max_reg <= ONE_Q16;
        end
        else
        begin
            state_reg       <= state_next;
            running_max_reg <= running_max_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_EXPOSURE:  exposure_reg  <= cfg_data;
                    REG_INV_GAMMA: inv_gamma_reg <= cfg_data;
                    REG_CHANNELS:  channels_reg  <= cfg_data[2:0];
                    default:       channels_reg  <= channels_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            last_reg <= frame_end;
        end
    end

    assign lane_cfg = '{exposure: exposure_reg, inv_gamma: inv_gamma_reg,
                        max: running_max_reg};

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        htm_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (start),
            .cfg    (lane_cfg),
            .sample (samples[k]),
            .done   (lane_done[k]),
            .result (lane_bytes[k])
        );
    end

    htm_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (merge_ctl),
        .lane_bytes (lane_bytes),
        .free       (merge_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .last_pixel (last_pixel)
    );

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> state_reg == TOP_BUSY)
        else $error("lane finished outside a conversion");

    a_max_floor: assert property (@(posedge clk) disable iff (!rst_n)
        running_max_reg >= ONE_Q16)
        else $error("running maximum below one");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == TOP_BUSY || state_reg == TOP_HOLD))
        else $error("result appeared without a conversion");

    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (&lane_done))
        else $error("lanes out of step");

endmodule

### rtl/core/htm_lane.sv
// one colour channel: ratio divide, log2, gamma, two exp2 passes, byte scaling
// depends on htm_pkg
module htm_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  htm_pkg::lane_cfg_t           cfg,
    input  logic [htm_pkg::SAMPLE_W-1:0] sample,
    output logic                         done,
    output logic [7:0]                   result
);
    import htm_pkg::*;

    lane_phase_t phase_reg, phase_next;
    logic [STEP_W-1:0]   count_reg, count_next;
    logic                second_reg;
    logic                sat_reg;
    logic                zero_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [RATIO_W-1:0]  quo_reg;
    logic [31:0]         x_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [3:0]          lead_reg;
    logic [EXPX_W-1:0]   ex_reg;
    logic [VAL_W-1:0]    v_reg;
    logic [7:0]          result_reg;
    logic                done_reg;

    logic [SAMPLE_W:0]   rem_dbl;
    logic                rem_ge;
    logic [RATIO_W-1:0]  ratio;
    logic [3:0]          lead;
    logic [63:0]         sq;
    logic [24:0]         log_val;
    logic [40:0]         gam_prod;
    logic [61:0]         root_prod;
    logic [46:0]         expo_prod;
    logic [59:0]         log2e_prod;
    logic [VAL_W-1:0]    diff;
    logic [38:0]         byte_prod;

    always_comb
    begin
        rem_dbl    = {rem_reg, 1'b0};
        rem_ge     = rem_dbl >= {1'b0, cfg.max};
        ratio      = sat_reg ? {RATIO_W{1'b1}} : quo_reg;
        lead       = '0;
        for (int i = 0; i < RATIO_W; i++)
        begin
            if (ratio[i])
            begin
                lead = 4'(i);
            end
        end
        sq         = 64'(x_reg) * 64'(x_reg);
        log_val    = {5'd16 - {1'b0, lead_reg}, {FRAC_W{1'b0}}} - 25'(frac_reg);
        gam_prod   = 41'(log_val) * 41'(cfg.inv_gamma);
        root_prod  = 62'(v_reg) * 62'(ROOT_TAB[count_reg]);
        expo_prod  = 47'(v_reg) * 47'(cfg.exposure);
        log2e_prod = 60'(ex_reg[28:0]) * 60'(LOG2E_Q30);
        diff       = ONE_Q30 - v_reg;
        byte_prod  = 39'(diff) * 39'(BYTE_FULL);
    end

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        unique case (phase_reg)
            LN_IDLE:
            begin
                if (start)
                begin
                    phase_next = LN_DIV;
                    count_next = '0;
                end
            end
            LN_DIV:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(RATIO_W - 1))
                begin
                    phase_next = LN_NORM;
                end
            end
            LN_NORM:
            begin
                phase_next = LN_LOG;
                count_next = '0;
            end
            LN_LOG:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(FRAC_W - 1))
                begin
                    phase_next = LN_GAMMA;
                end
            end
            LN_GAMMA:
            begin
                phase_next = LN_EXP;
                count_next = '0;
            end
            LN_EXP:
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == STEP_W'(FRAC_W - 1))
                begin
                    phase_next = LN_SHIFT;
                end
            end
            LN_SHIFT:
            begin
                phase_next = second_reg ? LN_FINAL : LN_EXPO;
            end
            LN_EXPO:
            begin
                phase_next = LN_LOG2E;
            end
            LN_LOG2E:
            begin
                phase_next = LN_EXP;
                count_next = '0;
            end
            LN_FINAL:
            begin
                phase_next = LN_IDLE;
            end
            default:
            begin
                phase_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LN_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            done_reg  <= phase_reg == LN_FINAL;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            LN_IDLE:
            begin
                if (start)
                begin
                    rem_reg <= sample;
                    sat_reg <= sample >= cfg.max;
                    quo_reg <= '0;
                end
            end
            LN_DIV:
            begin
                rem_reg <= rem_ge ? SAMPLE_W'(rem_dbl - {1'b0, cfg.max})
                                  : rem_dbl[SAMPLE_W-1:0];
                quo_reg <= {quo_reg[RATIO_W-2:0], rem_ge};
            end
            LN_NORM:
            begin
                zero_reg <= ratio == '0;
                lead_reg <= lead;
                x_reg    <= 32'({16'b0, ratio} << (5'd31 - {1'b0, lead}));
                frac_reg <= '0;
            end
            LN_LOG:
            begin
                if (sq[63])
                begin
                    x_reg    <= sq[63:32];
                    frac_reg <= {frac_reg[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    x_reg    <= sq[62:31];
                    frac_reg <= {frac_reg[FRAC_W-2:0], 1'b0};
                end
            end
            LN_GAMMA:
            begin
                ex_reg     <= EXPX_W'(gam_prod[40:12]);
                v_reg      <= ONE_Q30;
                second_reg <= 1'b0;
            end
            LN_EXP:
            begin
                if (ex_reg[STEP_W'(FRAC_W - 1) - count_reg])
                begin
                    v_reg <= root_prod[60:30];
                end
            end
            LN_SHIFT:
            begin
                if (ex_reg[EXPX_W-1:FRAC_W] >= 10'd31)
                begin
                    v_reg <= '0;
                end
                else
                begin
                    v_reg <= v_reg >> ex_reg[FRAC_W+4:FRAC_W];
                end
            end
            LN_EXPO:
            begin
                ex_reg <= EXPX_W'(expo_prod[46:18]);
            end
            LN_LOG2E:
            begin
                ex_reg     <= log2e_prod[59:30];
                v_reg      <= ONE_Q30;
                second_reg <= 1'b1;
            end
            LN_FINAL:
            begin
                result_reg <= zero_reg ? 8'd0 : byte_prod[37:30];
            end
            default:
            begin
                result_reg <= result_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/htm_merge.sv
// merges the lane bytes into one rgba item and holds it in the output register
// depends on htm_pkg
module htm_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  htm_pkg::merge_ctl_t         ctl,
    input  logic [htm_pkg::LANES-1:0][7:0] lane_bytes,
    output logic                        free,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_blue,
    output logic [7:0]                  out_alpha,
    output logic                        last_pixel
);
    import htm_pkg::*;

    logic                      valid_reg, valid_next;
    logic [LANES-1:0][7:0]     bytes_reg;
    logic [LANES-1:0][7:0]     bytes_next;
    logic                      last_reg;

    always_comb
    begin
        free = !valid_reg || out_ready;
        for (int k = 0; k < LANES; k++)
        begin
            if (3'(k) < ctl.count)
            begin
                bytes_next[k] = lane_bytes[k];
            end
            else
            begin
                bytes_next[k] = (k == LANES - 1) ? BYTE_FULL : 8'd0;
            end
        end
        if (ctl.load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            bytes_reg <= bytes_next;
            last_reg  <= ctl.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_red    = bytes_reg[0];
    assign out_green  = bytes_reg[1];
    assign out_blue   = bytes_reg[2];
    assign out_alpha  = bytes_reg[3];
    assign last_pixel = last_reg;

endmodule
